// File: design/pfe_pkg.sv
// ============================================================================
// pfe_pkg: shared types and constants of the postfix expression evaluator
// Character codes, status codes, and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package pfe_pkg;

    // Characters of the expression alphabet.
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DEPTH_W  = 5;
    localparam int unsigned STATUS_W = 3;

    // Status code reported with every result word.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the incoming character, clear on start
        logic push;      // push the digit value
        logic rd_b;      // read the second entry from the stack memory
        logic alu_load;  // register the add, subtract or multiply result
        logic div_start; // launch the divider
        logic load_q;    // register the quotient
        logic commit;    // write the result back and pop one entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic short_stack;
        logic div_zero;
        logic div_done;
    } t_dp_status;

endpackage

// File: design/pfe_ram.sv
// ============================================================================
// pfe_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module pfe_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/pfe_div.sv
// ============================================================================
// pfe_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the quotient
// is truncated toward zero and wraps for the most negative value over -1.
// ============================================================================
module pfe_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pfe_pkg::DATA_W-1:0]     i_num,
    input  logic [pfe_pkg::DATA_W-1:0]     i_den,
    output logic                           o_done,
    output logic [pfe_pkg::DATA_W-1:0]     o_quo
);

    localparam int unsigned W   = pfe_pkg::DATA_W;
    localparam int unsigned CNW = $clog2(W);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_quo;
    logic [W-1:0]   r_den;
    logic           r_neg;

    logic [W:0]     w_shift;
    logic [W:0]     w_diff;
    logic [W-1:0]   w_nmag;
    logic [W-1:0]   w_dmag;

    assign w_nmag  = i_num[W-1] ? (W'(0) - i_num) : i_num;
    assign w_dmag  = i_den[W-1] ? (W'(0) - i_den) : i_den;
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_nmag;
            r_den <= w_dmag;
            r_neg <= i_num[W-1] ^ i_den[W-1];
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

// File: design/pfe_dp.sv
// ============================================================================
// pfe_dp: evaluator datapath
// Stack memory, stack count, cached top of stack, arithmetic and divider.
// ============================================================================
module pfe_dp #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pfe_pkg::t_cmd                      i_cmd,
    input  logic [7:0]                         i_ch,
    input  logic                               i_start_req,
    output pfe_pkg::t_dp_status                o_stat,
    output logic signed [pfe_pkg::DATA_W-1:0]  o_top_value,
    output logic [pfe_pkg::DEPTH_W-1:0]        o_depth
);

    localparam int unsigned W  = pfe_pkg::DATA_W;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic [7:0]    r_ch;
    logic [CW-1:0] r_count;
    logic [W-1:0]  r_top;
    logic [W-1:0]  r_res;

    logic [CW-1:0] w_sub2;
    logic [7:0]    w_dig8;
    logic [W-1:0]  w_digit;
    logic [W-1:0]  w_b;
    logic [W-1:0]  w_alu;
    logic [W-1:0]  w_quo;
    logic          w_div_done;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [W-1:0]  w_wdata;
    logic [CW+pfe_pkg::DEPTH_W-1:0] w_depth_wide;

    assign w_sub2  = r_count - CW'(2);
    assign w_dig8  = r_ch - pfe_pkg::CH_ZERO;
    assign w_digit = {{(W-4){1'b0}}, w_dig8[3:0]};

    // Second operand comes straight from the registered memory read.
    always_comb begin
        case (r_ch)
            pfe_pkg::CH_PLUS:  w_alu = w_b + r_top;
            pfe_pkg::CH_MINUS: w_alu = w_b - r_top;
            default:           w_alu = w_b * r_top;
        endcase
    end

    assign w_we    = i_cmd.push | i_cmd.commit;
    assign w_waddr = i_cmd.push ? r_count[AW-1:0] : w_sub2[AW-1:0];
    assign w_wdata = i_cmd.push ? w_digit : r_res;

    pfe_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_b),
        .i_raddr (w_sub2[AW-1:0]),
        .o_rdata (w_b)
    );

    pfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_b),
        .i_den   (r_top),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_in) begin
            if (i_start_req) begin
                r_count <= '0;
            end
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.commit) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch <= i_ch;
        end
        if (i_cmd.push) begin
            r_top <= w_digit;
        end else if (i_cmd.commit) begin
            r_top <= r_res;
        end
        if (i_cmd.alu_load) begin
            r_res <= w_alu;
        end else if (i_cmd.load_q) begin
            r_res <= w_quo;
        end
    end

    assign o_stat.is_digit    = (r_ch >= pfe_pkg::CH_ZERO) && (r_ch <= pfe_pkg::CH_NINE);
    assign o_stat.is_op       = (r_ch == pfe_pkg::CH_PLUS) || (r_ch == pfe_pkg::CH_MINUS)
                             || (r_ch == pfe_pkg::CH_STAR) || (r_ch == pfe_pkg::CH_SLASH);
    assign o_stat.is_div      = (r_ch == pfe_pkg::CH_SLASH);
    assign o_stat.full        = (r_count >= CW'(STACK_DEPTH));
    assign o_stat.short_stack = (r_count < CW'(2));
    assign o_stat.div_zero    = (r_top == '0);
    assign o_stat.div_done    = w_div_done;

    // The depth field keeps the low five bits of the count.
    assign w_depth_wide = {{pfe_pkg::DEPTH_W{1'b0}}, r_count};
    assign o_depth      = w_depth_wide[pfe_pkg::DEPTH_W-1:0];
    assign o_top_value  = (r_count != '0) ? r_top : '0;

endmodule

// File: design/pfe_ctrl.sv
// ============================================================================
// pfe_ctrl: evaluator controller
// Sequences decode, operand read, arithmetic or division, write-back and
// the result handshake for one character at a time.
// ============================================================================
module pfe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  pfe_pkg::t_dp_status  i_stat,
    output pfe_pkg::t_cmd        o_cmd,
    output pfe_pkg::t_status     o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_WRITE,
        S_RESP
    } t_state;

    t_state           r_state;
    pfe_pkg::t_status r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= pfe_pkg::ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (i_stat.is_digit) begin
                        r_status <= i_stat.full ? pfe_pkg::ST_OVERFLOW : pfe_pkg::ST_OK;
                        r_state  <= S_RESP;
                    end else if (i_stat.is_op) begin
                        if (i_stat.short_stack) begin
                            r_status <= pfe_pkg::ST_UNDERFLOW;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_READ;
                        end
                    end else begin
                        r_status <= pfe_pkg::ST_UNKNOWN;
                        r_state  <= S_RESP;
                    end
                end
                S_READ: begin
                    if (!i_stat.is_div) begin
                        r_state <= S_WRITE;
                    end else if (i_stat.div_zero) begin
                        r_status <= pfe_pkg::ST_DIVZERO;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_status <= pfe_pkg::ST_OK;
                    r_state  <= S_RESP;
                end
                S_RESP: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.push      = (r_state == S_DECODE) && i_stat.is_digit && !i_stat.full;
        o_cmd.rd_b      = (r_state == S_DECODE) && !i_stat.is_digit && i_stat.is_op
                       && !i_stat.short_stack;
        o_cmd.alu_load  = (r_state == S_READ) && !i_stat.is_div;
        o_cmd.div_start = (r_state == S_READ) && i_stat.is_div && !i_stat.div_zero;
        o_cmd.load_q    = (r_state == S_DIV) && i_stat.div_done;
        o_cmd.commit    = (r_state == S_WRITE);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_status    = r_status;

endmodule

// File: design/postfix_expression_evaluator.sv
// ============================================================================
// postfix_expression_evaluator: postfix (RPN) evaluator on a bounded stack
// One character per word; digits push, + - * / combine the two top entries.
// ============================================================================
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_ch, i_start_req
//  out     | output    | o_out_valid/ i_out_ready| o_top_value, o_depth, o_status
//
//  One word at a time, one result word each. A digit, an unknown character or
//  an underflow goes from decode to the result; an operator reads its second
//  operand, a divide by zero stops there, and other operators write back, a
//  divide after the one-bit-per-cycle divider. Reset is synchronous and
//  active low and empties the stack; the memory contents are left as they are.
//  While a result waits for i_out_ready, the next input word is held off.
//
// The top of the stack is kept in a register beside the stack memory, so an
// operator needs only one memory read for its second operand. Memory entries
// above the count are never read, so the memory needs no clearing after
// reset.
module postfix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_ch,
    input  logic                               i_start_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pfe_pkg::DATA_W-1:0]  o_top_value,
    output logic [pfe_pkg::DEPTH_W-1:0]        o_depth,
    output logic [pfe_pkg::STATUS_W-1:0]       o_status
);

    pfe_pkg::t_cmd        w_cmd;
    pfe_pkg::t_dp_status  w_stat;
    pfe_pkg::t_status     w_status;

    // The controller sequences each word and owns the status code.
    pfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_status    (w_status)
    );

    // The datapath holds the stack and does the arithmetic.
    pfe_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .o_stat      (w_stat),
        .o_top_value (o_top_value),
        .o_depth     (o_depth)
    );

    assign o_status = w_status;

`ifndef ASSERT_OFF
    // Only one word is in the block at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    // A result is never offered in the cycle after its word was accepted.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result offered before the word was processed");

    // A delivered result is not repeated.
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid)
        else $error("result offered twice");

    // Underflow is only reported with fewer than two entries.
    a_underflow_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == pfe_pkg::ST_UNDERFLOW)) |-> (o_depth < 5'd2))
        else $error("underflow reported with a deep stack");
`endif

endmodule

// File: tb/tb_postfix_expression_evaluator.sv
// ============================================================================
// tb_postfix_expression_evaluator: self-checking bench for the RPN evaluator
// Feeds expression characters through the input channel, predicts the stack
// view (top value, depth, status) that each word must give, and checks every
// result word against that prediction in order. Directed rows come first,
// followed by randomly shaped expressions, overflow runs, wrap-around
// sequences, digits and operators in no particular order, and noise.
// ============================================================================
module tb_postfix_expression_evaluator;

    localparam int unsigned STACK_DEPTH  = 16;
    localparam int          DIRECTED_N   = 25;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          HOLD_AFTER   = 300;    // results before the long stall
    localparam int          HOLD_CYCLES  = 250;
    localparam int          MAX_REPORTS  = 10;

    // Characters outside the expression alphabet, some of them next to it and
    // some at the ends of the 8-bit range.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_HIGH_BIT = 8'h80;
    localparam logic [7:0] CH_ALL_ONES = 8'hFF;

    // What one result word reports.
    typedef struct packed {
        logic [pfe_pkg::DATA_W-1:0]  top;
        logic [pfe_pkg::DEPTH_W-1:0] depth;
        pfe_pkg::t_status            status;
    } t_stack_view;

    // One character to send. Where typed is set, the expected view is written
    // into the row by hand and replaces the predicted one.
    typedef struct packed {
        logic [7:0]                  ch;
        logic                        start;
        logic                        typed;
        logic [pfe_pkg::DATA_W-1:0]  top;
        logic [pfe_pkg::DEPTH_W-1:0] depth;
        pfe_pkg::t_status            status;
    } t_char_word;

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [7:0] i_ch;
    logic i_start_req;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [pfe_pkg::DATA_W-1:0] o_top_value;
    logic [pfe_pkg::DEPTH_W-1:0] o_depth;
    logic [pfe_pkg::STATUS_W-1:0] o_status;

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_top_value (o_top_value),
        .o_depth     (o_depth),
        .o_status    (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Directed rows. They start from the empty stack left by reset, so every
    // row's effect follows from the rows above it. Hand-written expectations
    // are given for the obvious cases (empty stack, extremes, error codes);
    // arithmetic rows are left to the predictor.
    // ------------------------------------------------------------------------
    t_char_word directed_tbl [DIRECTED_N] = '{
        // Operator straight after reset: nothing to pop.
        '{pfe_pkg::CH_PLUS,        1'b0, 1'b1, 32'd0, 5'd0, pfe_pkg::ST_UNDERFLOW},
        // Smallest and largest digit.
        '{pfe_pkg::CH_ZERO,        1'b0, 1'b1, 32'd0, 5'd1, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_NINE,        1'b0, 1'b1, 32'd9, 5'd2, pfe_pkg::ST_OK},
        // 0 - 9 gives a negative value, then -9 / 7 must truncate toward zero.
        '{pfe_pkg::CH_MINUS,       1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_SLASH,       1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        // Dividing by zero leaves both operands in place.
        '{pfe_pkg::CH_ZERO,        1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_SLASH,       1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_DIVZERO},
        // Characters just outside the alphabet and at the ends of the range.
        '{CH_SPACE,                1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_UNKNOWN},
        '{CH_NUL,                  1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_UNKNOWN},
        '{CH_ALL_ONES,             1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_UNKNOWN},
        '{CH_DOT,                  1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_UNKNOWN},
        '{CH_COLON,                1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_UNKNOWN},
        '{CH_COMMA,                1'b0, 1'b1, 32'd0, 5'd2, pfe_pkg::ST_UNKNOWN},
        // A start request empties the stack before the digit is pushed.
        '{pfe_pkg::CH_NINE,        1'b1, 1'b1, 32'd9, 5'd1, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_STAR,        1'b0, 1'b1, 32'd9, 5'd1, pfe_pkg::ST_UNDERFLOW},
        // 9 8 * 5 + 3 / : multiply, add and divide once more, with operand order.
        '{pfe_pkg::CH_ZERO + 8'd8, 1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_STAR,        1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_PLUS,        1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        '{pfe_pkg::CH_SLASH,       1'b0, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK},
        // Start request on an operator: the cleared stack cannot supply it.
        '{pfe_pkg::CH_STAR,        1'b1, 1'b1, 32'd0, 5'd0, pfe_pkg::ST_UNDERFLOW},
        '{pfe_pkg::CH_MINUS,       1'b0, 1'b1, 32'd0, 5'd0, pfe_pkg::ST_UNDERFLOW},
        '{CH_HIGH_BIT,             1'b1, 1'b1, 32'd0, 5'd0, pfe_pkg::ST_UNKNOWN}
    };

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_char_word  char_q[$];           // characters still to be offered
    t_stack_view stack_view_q[$];     // predicted views of accepted words

    logic [pfe_pkg::DATA_W-1:0] calc_stack [STACK_DEPTH];
    int unsigned                calc_count = 0;

    int  n_random    = 0;
    int  n_total     = 0;
    int  n_accepted  = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  n_reports   = 0;
    int  cycle_count = 0;
    int  n_by_status [5] = '{0, 0, 0, 0, 0};
    int  deepest     = 0;
    bit  feeding     = 1'b0;
    bit  hold_off    = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: applies one character to the bench's own copy of the stack
    // and returns the view that the block must report for it.
    // ------------------------------------------------------------------------
    function automatic logic [pfe_pkg::DATA_W-1:0] quot_trunc(
            logic [pfe_pkg::DATA_W-1:0] num, logic [pfe_pkg::DATA_W-1:0] den);
        logic [pfe_pkg::DATA_W-1:0] nmag;
        logic [pfe_pkg::DATA_W-1:0] dmag;
        logic [pfe_pkg::DATA_W-1:0] q;
        // Work on magnitudes so that the most negative value divided by -1
        // simply wraps back to itself.
        nmag = num[pfe_pkg::DATA_W-1] ? -num : num;
        dmag = den[pfe_pkg::DATA_W-1] ? -den : den;
        q    = nmag / dmag;
        return (num[pfe_pkg::DATA_W-1] ^ den[pfe_pkg::DATA_W-1]) ? -q : q;
    endfunction

    function automatic void evaluate_char(input logic [7:0] ch, input logic start,
                                          output t_stack_view view);
        logic [pfe_pkg::DATA_W-1:0] a;
        logic [pfe_pkg::DATA_W-1:0] b;
        logic [pfe_pkg::DATA_W-1:0] c;
        pfe_pkg::t_status           st;
        st = pfe_pkg::ST_OK;
        if (start) begin
            calc_count = 0;
        end
        if (ch >= pfe_pkg::CH_ZERO && ch <= pfe_pkg::CH_NINE) begin
            if (calc_count >= STACK_DEPTH) begin
                st = pfe_pkg::ST_OVERFLOW;
            end else begin
                calc_stack[calc_count] = {24'd0, ch - pfe_pkg::CH_ZERO};
                calc_count++;
            end
        end else if (ch == pfe_pkg::CH_PLUS || ch == pfe_pkg::CH_MINUS
                     || ch == pfe_pkg::CH_STAR || ch == pfe_pkg::CH_SLASH) begin
            if (calc_count < 2) begin
                st = pfe_pkg::ST_UNDERFLOW;
            end else begin
                a = calc_stack[calc_count - 1];
                b = calc_stack[calc_count - 2];
                c = '0;
                case (ch)
                    pfe_pkg::CH_PLUS: begin
                        c = b + a;
                    end
                    pfe_pkg::CH_MINUS: begin
                        c = b - a;
                    end
                    pfe_pkg::CH_STAR: begin
                        c = b * a;
                    end
                    default: begin
                        if (a == '0) begin
                            st = pfe_pkg::ST_DIVZERO;
                        end else begin
                            c = quot_trunc(b, a);
                        end
                    end
                endcase
                if (st == pfe_pkg::ST_OK) begin
                    calc_stack[calc_count - 2] = c;
                    calc_count--;
                end
            end
        end else begin
            st = pfe_pkg::ST_UNKNOWN;
        end
        view.top    = (calc_count > 0) ? calc_stack[calc_count - 1] : '0;
        view.depth  = calc_count[pfe_pkg::DEPTH_W-1:0];
        view.status = st;
    endfunction

    // ------------------------------------------------------------------------
    // Random stream builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] digit(int unsigned n);
        return pfe_pkg::CH_ZERO + 8'(n);
    endfunction

    function automatic logic [7:0] pick_op(int unsigned k);
        case (k)
            0:       return pfe_pkg::CH_PLUS;
            1:       return pfe_pkg::CH_MINUS;
            2:       return pfe_pkg::CH_STAR;
            default: return pfe_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic void add_char(logic [7:0] ch, logic start);
        char_q.push_back('{ch, start, 1'b0, 32'd0, 5'd0, pfe_pkg::ST_OK});
        n_random++;
    endfunction

    // A well-formed expression with random digits and operators, reduced to a
    // single value at the end. Most begin with a start request; the rest run
    // on from whatever the previous sequence left behind.
    function automatic void gen_expression();
        int d;
        int n;
        d = 0;
        n = $urandom_range(1, 24);
        repeat (n) begin
            if (d >= 2 && (d >= 12 || $urandom_range(0, 2) == 0)) begin
                add_char(pick_op($urandom_range(0, 3)), 1'b0);
                d--;
            end else begin
                add_char(digit($urandom_range(0, 9)), d == 0 && $urandom_range(0, 9) != 0);
                d++;
            end
        end
        while (d > 1) begin
            add_char(pick_op($urandom_range(0, 3)), 1'b0);
            d--;
        end
    endfunction

    // Fill the stack completely, push a few more to hit overflow, then unwind
    // part of it with random operators.
    function automatic void fill_to_overflow();
        add_char(digit($urandom_range(0, 9)), 1'b1);
        repeat (STACK_DEPTH - 1) add_char(digit($urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(1, 3)) add_char(digit($urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(0, STACK_DEPTH)) add_char(pick_op($urandom_range(0, 3)), 1'b0);
    endfunction

    // Ten eights and a two multiplied together give 2^31, which wraps to the
    // most negative value. It is then divided or multiplied by -1, or pushed
    // further past the end of the range.
    function automatic void min_by_minus_one();
        add_char(digit(8), 1'b1);
        repeat (9) add_char(digit(8), 1'b0);
        add_char(digit(2), 1'b0);
        repeat (10) add_char(pfe_pkg::CH_STAR, 1'b0);
        case ($urandom_range(0, 3))
            0: begin
                add_char(digit(0), 1'b0);
                add_char(digit(1), 1'b0);
                add_char(pfe_pkg::CH_MINUS, 1'b0);
                add_char(pfe_pkg::CH_SLASH, 1'b0);
            end
            1: begin
                add_char(digit(0), 1'b0);
                add_char(digit(1), 1'b0);
                add_char(pfe_pkg::CH_MINUS, 1'b0);
                add_char(pfe_pkg::CH_STAR, 1'b0);
            end
            2: begin
                add_char(digit($urandom_range(0, 9)), 1'b0);
                add_char(pfe_pkg::CH_MINUS, 1'b0);
            end
            default: begin
                add_char(digit($urandom_range(0, 9)), 1'b0);
                add_char(pick_op($urandom_range(0, 3)), 1'b0);
            end
        endcase
    endfunction

    // Digits and operators in no particular order, now and then restarted.
    function automatic void gen_broken();
        int k;
        repeat ($urandom_range(1, 8)) begin
            k = $urandom_range(0, 13);
            add_char(k < 10 ? digit(k) : pick_op(k - 10), $urandom_range(0, 7) == 0);
        end
    endfunction

    // Any byte at all, with the start flag at random.
    function automatic void gen_noise();
        repeat ($urandom_range(1, 4)) begin
            add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic void build_random_stream();
        int kind;
        // One deep run and one wrap-around run early on, so that both special
        // cases are certain to be reached whatever the seed.
        fill_to_overflow();
        min_by_minus_one();
        while (n_random < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                gen_expression();
            end else if (kind < 63) begin
                fill_to_overflow();
            end else if (kind < 70) begin
                min_by_minus_one();
            end else if (kind < 85) begin
                gen_broken();
            end else begin
                gen_noise();
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Words go out in bursts of random length separated by random
    // gaps; about a quarter of the bursts are followed by no gap at all. The
    // prediction is made at the edge where a word is accepted, so it always
    // sees the characters in the order the block does.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : char_feeder
        t_stack_view view;
        t_char_word  stim;
        logic        next_valid;
        static logic        cur_typed = 1'b0;
        static t_stack_view cur_view  = '0;
        static int          burst_left = 0;
        static int          gap_left   = 0;
        next_valid = i_in_valid;
        if (feeding) begin
            if (i_in_valid && o_in_ready) begin
                evaluate_char(i_ch, i_start_req, view);
                if (cur_typed) begin
                    view = cur_view;
                end
                stack_view_q.push_back(view);
                n_accepted <= n_accepted + 1;
                next_valid = 1'b0;
            end
            // A new word may only be presented once the current one is taken,
            // so valid never drops and the payload never changes while waiting.
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (char_q.size() > 0) begin
                    stim        = char_q.pop_front();
                    i_ch        <= stim.ch;
                    i_start_req <= stim.start;
                    cur_typed   = stim.typed;
                    cur_view    = '{stim.top, stim.depth, stim.status};
                    next_valid  = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // ------------------------------------------------------------------------
    // Receiver. Ready follows one of four patterns, picked anew at random:
    // always ready, a coin toss, ready a quarter of the time, or ready seven eighths of the time.
    // The long hold-off below overrides it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_sink
        logic      rdy;
        static int mode      = 0;
        static int mode_left = 0;
        static int phase     = 0;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(1, 64);
        end else begin
            mode_left--;
        end
        phase++;
        case (mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = (phase % 4) == 0;
            default: rdy = (phase % 8) != 0;
        endcase
        i_out_ready <= rdy && !hold_off;
    end

    // Once the run is well under way the receiver refuses results for a long
    // stretch while the sender keeps offering, so that the block backs up and
    // holds its input ready low.
    initial begin : long_stall
        wait (n_results >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result word is compared with the oldest
    // prediction still waiting.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : view_checker
        t_stack_view want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (o_status < 5) begin
                n_by_status[o_status]++;
            end
            if (int'(o_depth) > deepest) begin
                deepest = int'(o_depth);
            end
            if (stack_view_q.size() == 0) begin
                n_errors++;
                if (n_reports < MAX_REPORTS) begin
                    n_reports++;
                    $display("Unexpected result word: top %0d depth %0d status %0d",
                             o_top_value, o_depth, o_status);
                end
            end else begin
                want = stack_view_q.pop_front();
                n_results <= n_results + 1;
                if (o_top_value !== want.top || o_depth !== want.depth
                        || o_status !== want.status) begin
                    n_errors++;
                    if (n_reports < MAX_REPORTS) begin
                        n_reports++;
                        $display("Mismatch on word %0d: expected top %0d depth %0d status %0d,",
                                 n_results, $signed(want.top), want.depth, want.status);
                        $display("    got top %0d depth %0d status %0d",
                                 o_top_value, o_depth, o_status);
                    end
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles: %0d of %0d words accepted, %0d results",
                     cycle_count, n_accepted, n_total, n_results);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    initial begin : run_ctrl
        int k;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_ch        = '0;
        i_start_req = 1'b0;
        i_out_ready = 1'b0;
        for (k = 0; k < DIRECTED_N; k++) begin
            char_q.push_back(directed_tbl[k]);
        end
        build_random_stream();
        n_total = char_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        feeding <= 1'b1;

        // Everything sent, everything answered, then a quiet spell in case the
        // block produces anything it should not.
        wait (n_accepted == n_total);
        wait (n_results == n_total);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_errors += stack_view_q.size();

        $display("Checked %0d words (%0d random): ok %0d, underflow %0d, div by zero %0d,",
                 n_results, n_random, n_by_status[pfe_pkg::ST_OK],
                 n_by_status[pfe_pkg::ST_UNDERFLOW], n_by_status[pfe_pkg::ST_DIVZERO]);
        $display("    unknown %0d, overflow %0d; deepest stack %0d; %0d failures",
                 n_by_status[pfe_pkg::ST_UNKNOWN], n_by_status[pfe_pkg::ST_OVERFLOW],
                 deepest, n_errors);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: postfix_expression_evaluator.f
design/pfe_pkg.sv
design/pfe_ram.sv
design/pfe_div.sv
design/pfe_dp.sv
design/pfe_ctrl.sv
design/postfix_expression_evaluator.sv
tb/tb_postfix_expression_evaluator.sv
